@@ rtl/lpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	// Widths of the stream word and of the length register.
	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 16;

	// Reset value of the length limit.
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(1000);

	// Result queue geometry.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One result item as it leaves the block.
	typedef struct packed {
		logic signed [WORD_W-1:0] word_out;
		logic                     name_flag;
		logic                     last_flag;
		logic                     length_error;
	} out_item_t;

	// Up to two results written into the queue in one cycle.
	typedef struct packed {
		logic      push0;
		logic      push1;
		out_item_t item0;
		out_item_t item1;
	} push_t;

endpackage

@@ rtl/lpd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels of the deframer: input words, results, configuration.
// ----------------------------------------------------------------------------

// Input word channel.
interface lpd_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [lpd_pkg::WORD_W-1:0] word_in;

	modport source (output valid, output word_in, input ready);
	modport sink   (input valid, input word_in, output ready);
endinterface

// Result channel.
interface lpd_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [lpd_pkg::WORD_W-1:0] word_out;
	logic                             name_flag;
	logic                             last_flag;
	logic                             length_error;

	modport source (output valid, output word_out, output name_flag,
		output last_flag, output length_error, input ready);
	modport sink   (input valid, input word_out, input name_flag,
		input last_flag, input length_error, output ready);
endinterface

// Configuration write channel for the length limit.
interface lpd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lpd_pkg::LEN_W-1:0] max_length;

	modport source (output valid, output max_length, input ready);
	modport sink   (input valid, input max_length, output ready);
endinterface

@@ rtl/lpd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_parser
// Frame state machine: decodes each accepted word into zero, one or two
// results and keeps the frame name, the remaining count and the length limit.
// ----------------------------------------------------------------------------
module lpd_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic signed [lpd_pkg::WORD_W-1:0] word_in,
	input  logic                              cfg_we,
	input  logic [lpd_pkg::LEN_W-1:0]         cfg_max_length,
	output lpd_pkg::push_t                    push
);

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_NAME,
		PH_LEN,
		PH_DATA
	} phase_t;

	phase_t                            phase_q;
	logic signed [lpd_pkg::WORD_W-1:0] held_name_q;
	logic [lpd_pkg::LEN_W-1:0]         words_left_q;
	logic [lpd_pkg::LEN_W-1:0]         max_length_q;

	logic                              len_too_big;
	logic                              len_zero;
	logic                              last_data;
	lpd_pkg::out_item_t                name_item;

	// Length checks and the closing name item.
	assign len_too_big = $unsigned(word_in) > {{(lpd_pkg::WORD_W - lpd_pkg::LEN_W){1'b0}},
		max_length_q};
	assign len_zero    = (word_in == '0);
	assign last_data   = (words_left_q <= lpd_pkg::LEN_W'(1));

	always_comb begin
		name_item.word_out     = held_name_q;
		name_item.name_flag    = 1'b1;
		name_item.last_flag    = 1'b1;
		name_item.length_error = 1'b0;
	end

	// Results caused by the word on the input.
	always_comb begin
		push       = '0;
		push.item1 = name_item;
		unique case (phase_q)
			PH_LEN: begin
				if (len_too_big) begin
					push.push0              = accept;
					push.item0.length_error = 1'b1;
				end else if (len_zero) begin
					push.push0 = accept;
					push.item0 = name_item;
				end
			end
			PH_DATA: begin
				push.push0          = accept;
				push.push1          = accept & last_data;
				push.item0.word_out = word_in;
			end
			default: begin
			end
		endcase
	end

	// Phase, frame registers and the length limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC;
			held_name_q  <= '0;
			words_left_q <= '0;
			max_length_q <= lpd_pkg::MAX_LENGTH_RST;
		end else begin
			if (cfg_we) begin
				max_length_q <= cfg_max_length;
			end
			if (accept) begin
				unique case (phase_q)
					PH_SYNC: begin
						if (len_zero) begin
							phase_q <= PH_NAME;
						end
					end
					PH_NAME: begin
						held_name_q <= word_in;
						phase_q     <= PH_LEN;
					end
					PH_LEN: begin
						if (len_too_big || len_zero) begin
							phase_q <= PH_SYNC;
						end else begin
							words_left_q <= word_in[lpd_pkg::LEN_W-1:0];
							phase_q      <= PH_DATA;
						end
					end
					PH_DATA: begin
						if (last_data) begin
							words_left_q <= '0;
							phase_q      <= PH_SYNC;
						end else begin
							words_left_q <= words_left_q - lpd_pkg::LEN_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// A second result only ever follows a first one.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result without a first");

	// The payload phase never holds a zero count.
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (words_left_q != '0))
		else $error("payload phase with zero count");

	// Leaving the length phase into payload always loads a nonzero count.
	a_len_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_LEN && !len_too_big && !len_zero)
		|=> (phase_q == PH_DATA && words_left_q == $past(word_in[lpd_pkg::LEN_W-1:0])))
		else $error("count not loaded from length word");

endmodule

@@ rtl/lpd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module lpd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  lpd_pkg::push_t     push,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output lpd_pkg::out_item_t out_item
);

	lpd_pkg::out_item_t          mem_q [lpd_pkg::QUEUE_DEPTH];
	logic [lpd_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [lpd_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [lpd_pkg::QCNT_W-1:0]  count_q;
	logic [lpd_pkg::QPTR_W-1:0]  wr_next;
	logic [lpd_pkg::QCNT_W-1:0]  n_push;
	logic                        pop;

	// Room for a worst-case pair of results.
	assign space     = (count_q <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	assign wr_next   = wr_ptr_q + lpd_pkg::QPTR_W'(1);
	assign n_push    = lpd_pkg::QCNT_W'(push.push0) + lpd_pkg::QCNT_W'(push.push1);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.push1) begin
			mem_q[wr_next] <= push.item1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lpd_pkg::QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lpd_pkg::QPTR_W'(1);
			end
			count_q <= count_q + n_push - lpd_pkg::QCNT_W'(pop);
		end
	end

	// The fill count never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// Results are only written while there is room for a pair.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> space)
		else $error("result written without room");

	// Pointer distance agrees with the fill count.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[lpd_pkg::QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule

@@ rtl/length_prefixed_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Cuts a 32-bit word stream into sync / name / length / payload frames and
// emits payload words, then the frame name last (or a length error item).
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat payload
//  in_ch    in   word_in (one stream word)
//  out_ch   out  word_out, name_flag, last_flag, length_error
//  cfg      in   max_length (length limit)
//
// One input word is taken per cycle while input ready is high; its results
// land in a four-entry queue in the same cycle and can leave from the
// next cycle on. The final payload word yields two results, so the output
// side sets the sustained rate: one result per cycle while out_ch is ready.
// Input ready drops while the queue has room for fewer than two results.
// Reset (arst_n low) returns to sync hunting and sets the limit to 1000.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
module length_prefixed_deframer (
	input  logic      clk,
	input  logic      arst_n,
	lpd_in_if.sink    in_ch,
	lpd_out_if.source out_ch,
	lpd_cfg_if.sink   cfg
);

	lpd_pkg::push_t     push;
	lpd_pkg::out_item_t out_item;
	logic               space;
	logic               accept;

	// Input handshake.
	assign in_ch.ready = space;
	assign accept      = in_ch.valid & space;
	assign cfg.ready   = 1'b1;

	// Frame decoding.
	lpd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.word_in        (in_ch.word_in),
		.cfg_we         (cfg.valid),
		.cfg_max_length (cfg.max_length),
		.push           (push)
	);

	// Result queue.
	lpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_item)
	);

	// Output beat fields.
	assign out_ch.word_out     = out_item.word_out;
	assign out_ch.name_flag    = out_item.name_flag;
	assign out_ch.last_flag    = out_item.last_flag;
	assign out_ch.length_error = out_item.length_error;

endmodule

@@ test/lpd_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_result_checker
// Watches the deframer's input, result and configuration channels, works out
// the results each accepted stream word should cause and compares every
// accepted result beat with the oldest one still awaited.
// ----------------------------------------------------------------------------
module lpd_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	lpd_in_if           in_ch,
	lpd_out_if          out_ch,
	lpd_cfg_if          cfg,
	output int          fail_count,
	output int          pending,
	output int          results_checked,
	output int          names_seen,
	output int          rejects_seen
);

	// Parser position within a frame.
	typedef enum logic [1:0] {
		ST_HUNT,
		ST_NAME,
		ST_LENGTH,
		ST_PAYLOAD
	} frame_pos_t;

	frame_pos_t                         frame_pos;
	logic [lpd_pkg::WORD_W-1:0]         held_name;
	logic [lpd_pkg::LEN_W-1:0]          words_left;
	logic [lpd_pkg::LEN_W-1:0]          length_limit;
	lpd_pkg::out_item_t                 awaited[$];
	int                                 failures;

	assign fail_count = failures;

	// Appends one result to the awaited list.
	task queue_result(input logic [lpd_pkg::WORD_W-1:0] word, input logic is_name,
			input logic is_last, input logic is_reject);
		lpd_pkg::out_item_t item;
		item.word_out     = word;
		item.name_flag    = is_name;
		item.last_flag    = is_last;
		item.length_error = is_reject;
		awaited = {awaited, item};
	endtask

	// Advances the frame parser by one stream word and records its results.
	task deframe_word(input logic [lpd_pkg::WORD_W-1:0] word);
		case (frame_pos)
		ST_HUNT: begin
			if (word == '0)
				frame_pos = ST_NAME;
		end
		ST_NAME: begin
			held_name = word;
			frame_pos = ST_LENGTH;
		end
		ST_LENGTH: begin
			// The length word is compared as an unsigned 32-bit value.
			if (word > {{(lpd_pkg::WORD_W-lpd_pkg::LEN_W){1'b0}}, length_limit}) begin
				queue_result('0, 1'b0, 1'b0, 1'b1);
				frame_pos = ST_HUNT;
			end else if (word == '0) begin
				queue_result(held_name, 1'b1, 1'b1, 1'b0);
				frame_pos = ST_HUNT;
			end else begin
				words_left = word[lpd_pkg::LEN_W-1:0];
				frame_pos  = ST_PAYLOAD;
			end
		end
		default: begin
			queue_result(word, 1'b0, 1'b0, 1'b0);
			if (words_left <= 1) begin
				words_left = '0;
				queue_result(held_name, 1'b1, 1'b1, 1'b0);
				frame_pos = ST_HUNT;
			end else begin
				words_left = words_left - 1'b1;
			end
		end
		endcase
	endtask

	task check_field(input string field, input logic [lpd_pkg::WORD_W-1:0] want,
			input logic [lpd_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", field, want, got);
			failures++;
		end
	endtask

	// Compare result beats first: a result never stems from a word taken
	// at the same edge. A word taken at the edge of a limit write still
	// sees the old limit.
	always @(posedge clk or negedge arst_n) begin
		lpd_pkg::out_item_t oldest;
		if (!arst_n) begin
			awaited.delete();
			frame_pos       = ST_HUNT;
			held_name       = '0;
			words_left      = '0;
			length_limit    = lpd_pkg::MAX_LENGTH_RST;
			failures        = 0;
			results_checked = 0;
			names_seen      = 0;
			rejects_seen    = 0;
			pending        <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_checked++;
				if (awaited.size() == 0) begin
					$error("unexpected result beat: word_out %h name %b last %b error %b",
						out_ch.word_out, out_ch.name_flag, out_ch.last_flag,
						out_ch.length_error);
					failures++;
				end else begin
					oldest = awaited.pop_front();
					if (oldest.name_flag)
						names_seen++;
					if (oldest.length_error)
						rejects_seen++;
					check_field("word_out", oldest.word_out, out_ch.word_out);
					check_field("name_flag", lpd_pkg::WORD_W'(oldest.name_flag),
						lpd_pkg::WORD_W'(out_ch.name_flag));
					check_field("last_flag", lpd_pkg::WORD_W'(oldest.last_flag),
						lpd_pkg::WORD_W'(out_ch.last_flag));
					check_field("length_error", lpd_pkg::WORD_W'(oldest.length_error),
						lpd_pkg::WORD_W'(out_ch.length_error));
				end
			end
			if (in_ch.valid && in_ch.ready)
				deframe_word(in_ch.word_in);
			if (cfg.valid && cfg.ready)
				length_limit = cfg.max_length;
			pending <= awaited.size();
		end
	end

endmodule

@@ test/tb_length_prefixed_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_deframer
// Drives sync, name, length and payload words into the deframer, well formed
// and broken, under several length limits, with bursty input and a stalling
// result receiver. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_length_prefixed_deframer;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned PHASE_WORDS  = 120;
	localparam int unsigned SETTLE_TICKS = 4;

	// Receiver behaviours, redrawn at random.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_ONE_IN_FOUR,
		RX_BLOCKS
	} rx_mode_t;

	logic clk;
	logic arst_n;

	lpd_in_if  in_ch ();
	lpd_out_if out_ch ();
	lpd_cfg_if cfg ();

	int fail_count;
	int pending;
	int results_checked;
	int names_seen;
	int rejects_seen;

	int unsigned               cycle_count;
	int unsigned               burst_left;
	int unsigned               words_sent;
	int unsigned               limits_used;
	logic [lpd_pkg::LEN_W-1:0] limit_now;

	rx_mode_t    rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_hold_left;

	length_prefixed_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	lpd_result_checker results_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.cfg             (cfg),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.names_seen      (names_seen),
		.rejects_seen    (rejects_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog on the whole run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Result receiver: open, coin toss, one beat in four, or long blocks.
	initial begin
		rx_mode_left = 0;
		rx_hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 300);
			end
			rx_mode_left--;
			case (rx_mode)
			RX_OPEN:        out_ch.ready <= 1'b1;
			RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
			RX_ONE_IN_FOUR: out_ch.ready <= (rx_mode_left % 4 == 0);
			default: begin
				if (rx_hold_left == 0 && $urandom_range(0, 31) == 0)
					rx_hold_left = $urandom_range(5, 20);
				if (rx_hold_left != 0) begin
					rx_hold_left--;
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
			endcase
		end
	end

	// Sends one stream word, then perhaps closes the burst with a gap.
	task automatic put_word(input logic [lpd_pkg::WORD_W-1:0] word);
		int unsigned gap;
		in_ch.valid   <= 1'b1;
		in_ch.word_in <= word;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 5);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Holds the input back until every awaited result has left the block.
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_limit(input logic [lpd_pkg::LEN_W-1:0] limit);
		cfg.valid      <= 1'b1;
		cfg.max_length <= limit;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		limit_now = limit;
		limits_used++;
	endtask

	// Sync, name and length, then the given number of random payload words.
	task automatic send_frame(input logic [lpd_pkg::WORD_W-1:0] name,
			input logic [lpd_pkg::WORD_W-1:0] length, input int unsigned count);
		put_word('0);
		put_word(name);
		put_word(length);
		repeat (count) put_word($urandom);
	endtask

	// One random frame, mostly well formed; returns the words it counted.
	task automatic random_frame(output int unsigned counted);
		logic [lpd_pkg::WORD_W-1:0] name;
		logic [lpd_pkg::WORD_W-1:0] length;
		logic [lpd_pkg::WORD_W-1:0] limit_wide;
		int unsigned                pick;
		int unsigned                count;
		int unsigned                cap;
		pick = $urandom_range(0, 99);
		counted = 0;
		limit_wide = {{(lpd_pkg::WORD_W-lpd_pkg::LEN_W){1'b0}}, limit_now};
		case ($urandom_range(0, 7))
		0:       name = '0;
		1:       name = '1;
		2:       name = 32'h8000_0000;
		default: name = $urandom;
		endcase
		// Stray nonzero word, dropped while the parser hunts for sync.
		if (pick < 8) begin
			put_word($urandom_range(1, 32'hFFFF_FFFF));
			return;
		end
		case ($urandom_range(0, 9))
		0: length = '0;
		1: begin
			case ($urandom_range(0, 2))
			0:       length = limit_wide + 1;
			1:       length = 32'h8000_0000 | $urandom;
			default: length = 32'h0001_0000 + $urandom_range(0, 16'hFFFF);
			endcase
		end
		2: length = (limit_now <= 48) ? limit_wide : $urandom_range(1, 8);
		default: begin
			cap = ($urandom_range(0, 9) == 0) ? 40 : 8;
			if (cap > limit_wide)
				cap = limit_wide;
			length = (cap == 0) ? '0 : $urandom_range(1, cap);
		end
		endcase
		count = (length != 0 && length <= limit_wide) ? length : 0;
		if (pick < 16) begin
			// Broken frame: cut short after the name, after the length or inside the payload.
			if ($urandom_range(0, 2) == 0) begin
				put_word('0);
				put_word(name);
				counted = 2;
				return;
			end
			count = (count > 1) ? $urandom_range(0, count - 1) : 0;
		end
		send_frame(name, length, count);
		counted = 3 + count;
	endtask

	initial begin : stimulus
		logic [lpd_pkg::LEN_W-1:0] limit_plan[6];
		int unsigned               phase_words;
		int unsigned               counted;
		bit                        paused;
		burst_left  = 0;
		words_sent  = 0;
		limits_used = 0;
		limit_now   = lpd_pkg::MAX_LENGTH_RST;
		limit_plan  = '{16'hFFFF, 16'h0000, 16'd3, 16'd1, 16'd0, 16'd1000};
		limit_plan[4] = $urandom_range(0, 16'hFFFF);

		in_ch.valid    <= 1'b0;
		in_ch.word_in  <= '0;
		cfg.valid      <= 1'b0;
		cfg.max_length <= '0;
		arst_n         <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset limit.
		put_word('1);
		put_word(32'h8000_0000);
		send_frame(32'h7FFF_FFFF, '0, 0);
		put_word('0);
		put_word('0);
		put_word(32'd2);
		put_word('1);
		put_word('0);
		send_frame('1, 32'h8000_0000, 0);
		send_frame(32'h1234_5678, 32'd1001, 0);
		put_word(32'd5);
		send_frame(32'h8000_0000, 32'd1, 1);
		settle();

		// Random part, one phase per length limit.
		foreach (limit_plan[p]) begin
			write_limit(limit_plan[p]);
			if (limit_now == 16'hFFFF) begin
				send_frame($urandom, 32'h0001_0000, 0);
				send_frame($urandom, '1, 0);
			end
			phase_words = 0;
			paused = 1'b0;
			while (phase_words < PHASE_WORDS) begin
				random_frame(counted);
				phase_words += counted;
				if (!paused && phase_words >= PHASE_WORDS / 2) begin
					settle();
					paused = 1'b1;
				end
			end
			settle();
		end

		repeat (SETTLE_TICKS * 4) @(posedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);

		$display("Sent %0d stream words under %0d length limits, with gaps and stalls.",
			words_sent, limits_used + 1);
		$display("Compared %0d results: %0d closed by their name, %0d lengths rejected.",
			results_checked, names_seen, rejects_seen);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/lpd_parser.sv
rtl/lpd_queue.sv
rtl/length_prefixed_deframer.sv
test/lpd_result_checker.sv
test/tb_length_prefixed_deframer.sv
